[hdl/twofish_h_function_core_defines.svh]
// Assertion macros shared by the Twofish h function core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TWOFISH_H_FUNCTION_CORE_DEFINES_SVH
`define TWOFISH_H_FUNCTION_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TWH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("twofish h core: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define TWH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("twofish h core: next-cycle check failed");

`endif

[hdl/twh_pkg.sv]
// Package for the Twofish h function core: types, register map, q-box
// nibble tables, MDS matrix and the GF(2^8) helper functions. No dependencies.
`timescale 1ns / 1ps

package twh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  key_len_t;

  // Register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_KEY_WORD_ZERO  = 3'd0,
    REG_KEY_WORD_ONE   = 3'd1,
    REG_KEY_WORD_TWO   = 3'd2,
    REG_KEY_WORD_THREE = 3'd3,
    REG_KEY_WORDS      = 3'd4
  } twh_reg_e;

  localparam int unsigned ApbAddrWidth = 5;

  // Legal key lengths in 64-bit words
  localparam key_len_t KEY_LEN_128 = 3'd2;
  localparam key_len_t KEY_LEN_192 = 3'd3;
  localparam key_len_t KEY_LEN_256 = 3'd4;

  // Key words and key length, as seen by the datapath
  typedef struct packed {
    word_t    k0;
    word_t    k1;
    word_t    k2;
    word_t    k3;
    key_len_t len;
  } twh_key_t;

  // q0/q1 choice per byte, bit i for byte i (1 selects q1)
  localparam logic [3:0] SEL_K3    = 4'b1001;
  localparam logic [3:0] SEL_K2    = 4'b0011;
  localparam logic [3:0] SEL_K1    = 4'b1010;
  localparam logic [3:0] SEL_K0    = 4'b1100;
  localparam logic [3:0] SEL_FINAL = 4'b0101;

  // Low byte of the reduction polynomial x^8+x^6+x^5+x^3+1
  localparam byte_t GF_POLY_LOW = 8'h69;

  // Nibble tables t0..t3 for q0 and q1
  localparam logic [3:0] NIB_TAB [2][4][16] = '{
    '{
      '{4'h8, 4'h1, 4'h7, 4'hD, 4'h6, 4'hF, 4'h3, 4'h2,
        4'h0, 4'hB, 4'h5, 4'h9, 4'hE, 4'hC, 4'hA, 4'h4},
      '{4'hE, 4'hC, 4'hB, 4'h8, 4'h1, 4'h2, 4'h3, 4'h5,
        4'hF, 4'h4, 4'hA, 4'h6, 4'h7, 4'h0, 4'h9, 4'hD},
      '{4'hB, 4'hA, 4'h5, 4'hE, 4'h6, 4'hD, 4'h9, 4'h0,
        4'hC, 4'h8, 4'hF, 4'h3, 4'h2, 4'h4, 4'h7, 4'h1},
      '{4'hD, 4'h7, 4'hF, 4'h4, 4'h1, 4'h2, 4'h6, 4'hE,
        4'h9, 4'hB, 4'h3, 4'h0, 4'h8, 4'h5, 4'hC, 4'hA}
    },
    '{
      '{4'h2, 4'h8, 4'hB, 4'hD, 4'hF, 4'h7, 4'h6, 4'hE,
        4'h3, 4'h1, 4'h9, 4'h4, 4'h0, 4'hA, 4'hC, 4'h5},
      '{4'h1, 4'hE, 4'h2, 4'hB, 4'h4, 4'hC, 4'h3, 4'h7,
        4'h6, 4'hD, 4'hA, 4'h5, 4'hF, 4'h9, 4'h0, 4'h8},
      '{4'h4, 4'hC, 4'h7, 4'h5, 4'h1, 4'h6, 4'h9, 4'hA,
        4'h0, 4'hE, 4'hD, 4'h8, 4'h2, 4'hB, 4'h3, 4'hF},
      '{4'hB, 4'h9, 4'h5, 4'h1, 4'hC, 4'h3, 4'hD, 4'hE,
        4'h6, 4'h4, 4'h7, 4'hF, 4'h2, 4'h0, 4'h8, 4'hA}
    }
  };

  // MDS matrix, row i gives output byte i
  localparam byte_t MDS_MAT [4][4] = '{
    '{8'h01, 8'hEF, 8'h5B, 8'h5B},
    '{8'h5B, 8'hEF, 8'hEF, 8'h01},
    '{8'hEF, 8'h5B, 8'h01, 8'hEF},
    '{8'hEF, 8'h01, 8'hEF, 8'h5B}
  };

  // Rotate a nibble right by one
  function automatic logic [3:0] ror4(input logic [3:0] v);
    return {v[0], v[3:1]};
  endfunction

  // q permutation: sel 0 = q0, sel 1 = q1
  function automatic byte_t q_perm(input byte_t x, input logic sel);
    logic [3:0] a0, b0, a1, b1, a2, b2, a3, b3, a4, b4;
    a0 = x[7:4];
    b0 = x[3:0];
    a1 = a0 ^ b0;
    b1 = a0 ^ ror4(b0) ^ {a0[0], 3'b000};
    a2 = NIB_TAB[sel][0][a1];
    b2 = NIB_TAB[sel][1][b1];
    a3 = a2 ^ b2;
    b3 = a2 ^ ror4(b2) ^ {a2[0], 3'b000};
    a4 = NIB_TAB[sel][2][a3];
    b4 = NIB_TAB[sel][3][b3];
    return {b4, a4};
  endfunction

  // GF(2^8) product; with a constant k this folds to a few XOR gates
  function automatic byte_t gf_mul(input byte_t k, input byte_t b);
    byte_t acc;
    byte_t sh;
    acc = '0;
    sh  = b;
    for (int i = 0; i < 8; i++) begin
      if (k[i]) begin
        acc = acc ^ sh;
      end
      sh = sh[7] ? ({sh[6:0], 1'b0} ^ GF_POLY_LOW) : {sh[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

[hdl/twh_keyed_sbox.sv]
// Key-dependent byte substitution of the h function: q-box chains with
// key-byte XORs for all four bytes. Depends on twh_pkg.
`timescale 1ns / 1ps

module twh_keyed_sbox (
  input  twh_pkg::word_t   in_word_i,
  input  twh_pkg::twh_key_t key_i,
  output twh_pkg::word_t   sbox_word_o
);
  import twh_pkg::*;

  // Run each byte through its q chain; stages in front drop out for short keys
  always_comb begin
    byte_t v;
    for (int i = 0; i < 4; i++) begin
      v = in_word_i[8*i +: 8];
      if (key_i.len == KEY_LEN_256) begin
        v = q_perm(v, SEL_K3[i]) ^ key_i.k3[8*i +: 8];
      end
      if (key_i.len == KEY_LEN_192 || key_i.len == KEY_LEN_256) begin
        v = q_perm(v, SEL_K2[i]) ^ key_i.k2[8*i +: 8];
      end
      v = q_perm(v, SEL_K1[i]) ^ key_i.k1[8*i +: 8];
      v = q_perm(v, SEL_K0[i]) ^ key_i.k0[8*i +: 8];
      sbox_word_o[8*i +: 8] = q_perm(v, SEL_FINAL[i]);
    end
  end

endmodule

[hdl/twh_mds.sv]
// MDS matrix multiply over GF(2^8) with the 0x169 polynomial.
// Depends on twh_pkg.
`timescale 1ns / 1ps

module twh_mds (
  input  twh_pkg::word_t y_word_i,
  output twh_pkg::word_t z_word_o
);
  import twh_pkg::*;

  // Each output byte is the XOR of four constant products
  always_comb begin
    byte_t z;
    for (int i = 0; i < 4; i++) begin
      z = '0;
      for (int j = 0; j < 4; j++) begin
        z = z ^ gf_mul(MDS_MAT[i][j], y_word_i[8*j +: 8]);
      end
      z_word_o[8*i +: 8] = z;
    end
  end

endmodule

[hdl/twofish_h_function_core.sv]
// Twofish h function core: key registers on an APB-style port, input register,
// keyed S-box and MDS logic, result register. Depends on twh_pkg,
// twh_keyed_sbox, twh_mds and twofish_h_function_core_defines.svh.
//
//  Channel   Direction  Payload / use
//  s_axis    in         tdata[31:0] = in_word
//  m_axis    out        tdata[31:0] = out_word
//  apb       in/out     key_word_zero..three at 0x00..0x0C, key_words_in_use at 0x10
//
// The input register captures each input transaction and the result register loads from it
// when out_ready is high, so a stall on m_axis_tready can hold a result back; the path
// between the registers is the full q-box chain plus the MDS multiply. One transaction per
// cycle sustained while m_axis_tready stays high.
// The input register can take one more transaction while a result waits on m_axis_tready.
// Reset clears both valid flags, zeroes the key words and sets a 128-bit key.
`timescale 1ns / 1ps

`include "twofish_h_function_core_defines.svh"

module twofish_h_function_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream; tdata: [31:0] in_word
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,
  // result stream; tdata: [31:0] out_word
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [twh_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import twh_pkg::*;

  twh_key_t key_q;
  word_t    in_word_q;
  logic     in_valid_q;
  word_t    out_word_q;
  logic     out_valid_q;
  logic     out_ready;
  logic     cfg_write;
  twh_reg_e reg_idx;
  word_t    sbox_word;
  word_t    mds_word;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_idx   = twh_reg_e'(paddr[ApbAddrWidth-1:2]);

  // Key registers; illegal key lengths are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.k0  <= '0;
      key_q.k1  <= '0;
      key_q.k2  <= '0;
      key_q.k3  <= '0;
      key_q.len <= KEY_LEN_128;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_KEY_WORD_ZERO:  key_q.k0 <= pwdata;
        REG_KEY_WORD_ONE:   key_q.k1 <= pwdata;
        REG_KEY_WORD_TWO:   key_q.k2 <= pwdata;
        REG_KEY_WORD_THREE: key_q.k3 <= pwdata;
        REG_KEY_WORDS: begin
          if (pwdata[2:0] inside {KEY_LEN_128, KEY_LEN_192, KEY_LEN_256}) begin
            key_q.len <= pwdata[2:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_KEY_WORD_ZERO:  prdata = key_q.k0;
      REG_KEY_WORD_ONE:   prdata = key_q.k1;
      REG_KEY_WORD_TWO:   prdata = key_q.k2;
      REG_KEY_WORD_THREE: prdata = key_q.k3;
      REG_KEY_WORDS:      prdata = {29'd0, key_q.len};
      default:            prdata = '0;
    endcase
  end

  // Stage handshake: each register takes new data when empty or draining
  assign out_ready     = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | out_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
    end
  end

  twh_keyed_sbox u_sbox (
    .in_word_i   (in_word_q),
    .key_i       (key_q),
    .sbox_word_o (sbox_word)
  );

  twh_mds u_mds (
    .y_word_i (sbox_word),
    .z_word_o (mds_word)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_word_q <= mds_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;

  // Checks
  `TWH_ASSERT_SAME(a_key_len_legal, 1'b1,
      key_q.len == KEY_LEN_128 || key_q.len == KEY_LEN_192 || key_q.len == KEY_LEN_256)
  `TWH_ASSERT_NEXT(a_in_captured, s_axis_tvalid && s_axis_tready, in_valid_q)
  `TWH_ASSERT_NEXT(a_in_held, in_valid_q && !out_ready,
      in_valid_q && $stable(in_word_q))
  `TWH_ASSERT_NEXT(a_result_loaded, in_valid_q && out_ready,
      out_valid_q && out_word_q == $past(mds_word))
  `TWH_ASSERT_SAME(a_accept_while_stalled, !in_valid_q && out_valid_q && !m_axis_tready,
      s_axis_tready)

endmodule
